/* rtl/core/latency_tone_tick_generator_core_macros.svh */
// Assertion helpers shared by the core modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LATENCY_TONE_TICK_GENERATOR_CORE_MACROS_SVH
`define LATENCY_TONE_TICK_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define LTTG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lttg assertion failed");

// Next-cycle implication.
`define LTTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lttg assertion failed");

`endif

/* rtl/core/lttg_pkg.sv */
package lttg_pkg;

  typedef enum logic [2:0] {
    CFG_TONE_PHASE_STEP,
    CFG_LEAD_IN_GAIN,
    CFG_TONE_GAIN,
    CFG_LEAD_IN_END,
    CFG_FIRST_TICK_START,
    CFG_SECOND_TICK_START,
    CFG_THIRD_TICK_START,
    CFG_PATTERN_LENGTH
  } cfg_reg_t;

  localparam logic [31:0] RST_TONE_PHASE_STEP   = 32'd89478485;
  localparam logic [15:0] RST_LEAD_IN_GAIN      = 16'd0;
  localparam logic [15:0] RST_TONE_GAIN         = 16'd131;
  localparam logic [23:0] RST_LEAD_IN_END       = 24'd0;
  localparam logic [23:0] RST_FIRST_TICK_START  = 24'd48000;
  localparam logic [23:0] RST_SECOND_TICK_START = 24'd72000;
  localparam logic [23:0] RST_THIRD_TICK_START  = 24'd96000;
  localparam logic [23:0] RST_PATTERN_LENGTH    = 24'd144000;

  localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
  localparam logic [15:0] TICK_GAIN_Q16 = 16'd65405;
  localparam logic signed [18:0] SAT_POS = 19'sd32767;
  localparam logic signed [18:0] SAT_NEG = -19'sd32767;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified sample period handed from the front to the back.
  typedef struct packed {
    logic [31:0] phase;
    logic [15:0] amp;
    logic [17:0] tick_sum;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Quarter-wave Taylor series in Q30, rounded to a Q1.15 magnitude.
  function automatic logic [15:0] taylor_q15(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return v[15:0];
  endfunction

endpackage

/* rtl/core/lttg_period_if.sv */
interface lttg_period_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

/* rtl/core/lttg_audio_if.sv */
interface lttg_audio_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample;
  logic              pattern_end;

  modport source (output valid, output sample, output pattern_end, input ready);
  modport sink (input valid, input sample, input pattern_end, output ready);
endinterface

/* rtl/core/lttg_cfg_if.sv */
interface lttg_cfg_if;
  logic                valid;
  logic                ready;
  lttg_pkg::cfg_reg_t  index;
  logic [31:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/latency_tone_tick_generator_core.sv */
// Channel   Role     Payload
// period    sink     restart: one transaction per sample period
// audio     source   sample (signed Q1.15), pattern_end
// cfg       sink     index, data: one register write per transaction
//
// One sample period is accepted per cycle while the queue is not full; its sample passes
// through the command queue and the four-stage table, gain and saturation pipeline.
// Reset clears the sample index, phase, queue and pipeline and loads the register defaults.
// A stalled audio channel freezes the pipeline; the four-entry queue then fills and
// period.ready falls until samples are taken again.
module latency_tone_tick_generator_core #(
  parameter int TICK_LENGTH      = 4,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input logic          clk,
  input logic          rst,
  lttg_period_if.sink  period,
  lttg_audio_if.source audio,
  lttg_cfg_if.sink     cfg
);
  import lttg_pkg::*;

  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;
  queue_status_t status;

  lttg_front #(
    .TICK_LENGTH(TICK_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .period   (period),
    .cfg      (cfg),
    .status   (status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lttg_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  lttg_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .status (status),
    .pop    (pop),
    .audio  (audio)
  );

endmodule

/* rtl/core/lttg_front.sv */
`include "latency_tone_tick_generator_core_macros.svh"

module lttg_front #(
  parameter int TICK_LENGTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  lttg_period_if.sink             period,
  lttg_cfg_if.sink                cfg,
  input  lttg_pkg::queue_status_t status,
  output logic                    push,
  output lttg_pkg::cmd_t          push_cmd
);
  import lttg_pkg::*;

  localparam int OFS_W = $clog2(TICK_LENGTH);

  typedef logic signed [15:0] tick_rom_t [TICK_LENGTH];

  function automatic tick_rom_t build_tick_rom();
    tick_rom_t   rom;
    logic [63:0] n;
    logic [63:0] x;
    logic [63:0] m;
    logic        neg;
    logic [15:0] mag;
    for (int k = 0; k < TICK_LENGTH; k++) begin
      n   = 64'(4 * k);
      neg = 1'b0;
      if (n >= 64'(2 * TICK_LENGTH)) begin
        neg = 1'b1;
        n   = n - 64'(2 * TICK_LENGTH);
      end
      if (n > 64'(TICK_LENGTH)) n = 64'(2 * TICK_LENGTH) - n;
      x   = (n * HALF_PI_Q30) / 64'(TICK_LENGTH);
      mag = taylor_q15(x);
      m   = (64'(mag) * 64'(TICK_GAIN_Q16) + 64'd32768) >> 16;
      rom[k] = neg ? -$signed(m[15:0]) : $signed(m[15:0]);
    end
    return rom;
  endfunction

  localparam tick_rom_t TICK_ROM = build_tick_rom();

  logic [31:0] tone_phase_step;
  logic [15:0] lead_in_gain;
  logic [15:0] tone_gain;
  logic [23:0] lead_in_end;
  logic [23:0] tick_start [3];
  logic [23:0] pattern_length;

  logic [23:0] sample_index;
  logic [23:0] sample_index_next;
  logic [31:0] tone_phase;
  logic [31:0] tone_phase_next;

  logic               accept;
  logic [23:0]        cur_index;
  logic [31:0]        cur_phase;
  logic [23:0]        len;
  logic               last;
  logic signed [15:0] tick_val [3];
  logic signed [17:0] tick_sum;

  assign cfg.ready    = 1'b1;
  assign period.ready = !status.full;
  assign accept       = period.valid && period.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_phase_step <= RST_TONE_PHASE_STEP;
      lead_in_gain    <= RST_LEAD_IN_GAIN;
      tone_gain       <= RST_TONE_GAIN;
      lead_in_end     <= RST_LEAD_IN_END;
      tick_start[0]   <= RST_FIRST_TICK_START;
      tick_start[1]   <= RST_SECOND_TICK_START;
      tick_start[2]   <= RST_THIRD_TICK_START;
      pattern_length  <= RST_PATTERN_LENGTH;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_TONE_PHASE_STEP:   tone_phase_step <= cfg.data;
        CFG_LEAD_IN_GAIN:      lead_in_gain    <= cfg.data[15:0];
        CFG_TONE_GAIN:         tone_gain       <= cfg.data[15:0];
        CFG_LEAD_IN_END:       lead_in_end     <= cfg.data[23:0];
        CFG_FIRST_TICK_START:  tick_start[0]   <= cfg.data[23:0];
        CFG_SECOND_TICK_START: tick_start[1]   <= cfg.data[23:0];
        CFG_THIRD_TICK_START:  tick_start[2]   <= cfg.data[23:0];
        CFG_PATTERN_LENGTH:    pattern_length  <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_index = period.restart ? '0 : sample_index;
    cur_phase = period.restart ? '0 : tone_phase;
    len       = (pattern_length == '0) ? 24'd1 : pattern_length;
    last      = ({1'b0, cur_index} + 25'd1) >= {1'b0, len};
  end

  always_comb begin
    logic [23:0] diff;
    for (int t = 0; t < 3; t++) begin
      diff = cur_index - tick_start[t];
      if (cur_index >= tick_start[t] && diff < 24'(TICK_LENGTH)) begin
        tick_val[t] = TICK_ROM[diff[OFS_W-1:0]];
      end else begin
        tick_val[t] = '0;
      end
    end
    tick_sum = 18'(tick_val[0]) + 18'(tick_val[1]) + 18'(tick_val[2]);
  end

  always_comb begin
    push              = accept;
    push_cmd.phase    = cur_phase;
    push_cmd.amp      = (cur_index < lead_in_end && lead_in_gain > tone_gain)
                        ? lead_in_gain : tone_gain;
    push_cmd.tick_sum = tick_sum;
    push_cmd.last     = last;
  end

  always_comb begin
    sample_index_next = sample_index;
    tone_phase_next   = tone_phase;
    if (accept) begin
      if (last) begin
        sample_index_next = '0;
        tone_phase_next   = '0;
      end else begin
        sample_index_next = cur_index + 24'd1;
        tone_phase_next   = cur_phase + tone_phase_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      tone_phase   <= '0;
    end else begin
      sample_index <= sample_index_next;
      tone_phase   <= tone_phase_next;
    end
  end

  `LTTG_ASSERT_NEXT(a_wrap_clears, accept && last, sample_index == '0 && tone_phase == '0)
  `LTTG_ASSERT_NEXT(a_index_steps, accept && !last, sample_index == $past(cur_index) + 24'd1)
  `LTTG_ASSERT_NEXT(a_idle_holds, !accept, $stable(sample_index) && $stable(tone_phase))

endmodule

/* rtl/core/lttg_cmd_queue.sv */
module lttg_cmd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  lttg_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output lttg_pkg::cmd_t          head,
  output lttg_pkg::queue_status_t status
);
  import lttg_pkg::*;

  cmd_t                   store [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  function automatic logic [QUEUE_PTR_W-1:0] bump(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CNT_W'(1);
        2'b01:   count <= count - QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign head         = store[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

/* rtl/core/lttg_back.sv */
`include "latency_tone_tick_generator_core_macros.svh"

module lttg_back #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lttg_pkg::cmd_t          head,
  input  lttg_pkg::queue_status_t status,
  output logic                    pop,
  lttg_audio_if.source            audio
);
  import lttg_pkg::*;

  localparam int TAB_W = $clog2(SINE_TABLE_DEPTH);
  localparam int DEP_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = 32 + DEP_W;

  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] n;
    logic [63:0] x;
    logic        neg;
    logic [15:0] mag;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      n   = 64'(4 * k);
      neg = 1'b0;
      if (n >= 64'(2 * SINE_TABLE_DEPTH)) begin
        neg = 1'b1;
        n   = n - 64'(2 * SINE_TABLE_DEPTH);
      end
      if (n > 64'(SINE_TABLE_DEPTH)) n = 64'(2 * SINE_TABLE_DEPTH) - n;
      x   = (n * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
      mag = taylor_q15(x);
      rom[k] = neg ? -$signed(mag) : $signed(mag);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic              en;
  logic [PROD_W-1:0] idx_prod;

  logic              v1;
  logic [TAB_W-1:0]  idx1;
  logic [15:0]       amp1;
  logic [17:0]       tick1;
  logic              last1;

  logic              v2;
  logic signed [15:0] sine2;
  logic [15:0]       amp2;
  logic [17:0]       tick2;
  logic              last2;

  logic              v3;
  logic [14:0]       mag3;
  logic              neg3;
  logic [17:0]       tick3;
  logic              last3;

  logic [15:0]       abs2;
  logic [31:0]       scaled2;
  logic signed [16:0] tone3;
  logic signed [18:0] total3;
  logic signed [15:0] sat3;

  logic              out_valid;
  logic signed [15:0] out_sample;
  logic              out_end;

  assign en  = !out_valid || audio.ready;
  assign pop = en && !status.empty;

  assign idx_prod = PROD_W'(head.phase) * PROD_W'(SINE_TABLE_DEPTH);

  always_comb begin
    abs2    = sine2[15] ? 16'(-sine2) : sine2;
    scaled2 = 32'(abs2[14:0]) * 32'(amp2) + 32'd32768;
    tone3   = neg3 ? -$signed({2'b00, mag3}) : $signed({2'b00, mag3});
    total3  = 19'(tone3) + 19'($signed(tick3));
    if (total3 > SAT_POS) begin
      sat3 = 16'(SAT_POS);
    end else if (total3 < SAT_NEG) begin
      sat3 = 16'(SAT_NEG);
    end else begin
      sat3 = total3[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1       <= idx_prod[32 +: TAB_W];
      amp1       <= head.amp;
      tick1      <= head.tick_sum;
      last1      <= head.last;
      sine2      <= SINE_ROM[idx1];
      amp2       <= amp1;
      tick2      <= tick1;
      last2      <= last1;
      mag3       <= scaled2[30:16];
      neg3       <= sine2[15];
      tick3      <= tick2;
      last3      <= last2;
      out_sample <= sat3;
      out_end    <= last3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= pop;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  assign audio.valid       = out_valid;
  assign audio.sample      = out_sample;
  assign audio.pattern_end = out_end;

  `LTTG_ASSERT_NEXT(a_stall_freezes, !en, $stable({v1, v2, v3}))
  `LTTG_ASSERT_NEXT(a_pop_enters, pop, v1)
  `LTTG_ASSERT_NEXT(a_last_stage_lands, en && v3, audio.valid)

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import lttg_pkg::*;

  localparam int TICK_LEN    = 4;
  localparam int SINE_DEPTH  = 1024;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
  } audio_item_t;

  typedef struct {
    logic [31:0] phase_step;
    logic [31:0] lead_gain;
    logic [31:0] tone_gain;
    logic [31:0] lead_end;
    logic [31:0] tick1;
    logic [31:0] tick2;
    logic [31:0] tick3;
    logic [31:0] length;
  } tone_settings_t;

  class tone_scoreboard;
    int          sine_tab[SINE_DEPTH];
    int          tick_tab[TICK_LEN];
    logic [31:0] phase_step;
    logic [15:0] lead_gain;
    logic [15:0] tone_gain;
    logic [23:0] lead_end;
    logic [23:0] tick_start[3];
    logic [23:0] length;
    logic [23:0] index;
    logic [31:0] phase;
    audio_item_t due_samples[$];
    int          errors;
    int          reported;

    function new();
      int k;
      for (k = 0; k < SINE_DEPTH; k++) sine_tab[k] = sine_point(k, SINE_DEPTH);
      for (k = 0; k < TICK_LEN; k++) begin
        tick_tab[k] = gain_scale(sine_point(k, TICK_LEN), 16'd65405);
      end
      phase_step    = 32'd89478485;
      lead_gain     = 16'd0;
      tone_gain     = 16'd131;
      lead_end      = 24'd0;
      tick_start[0] = 24'd48000;
      tick_start[1] = 24'd72000;
      tick_start[2] = 24'd96000;
      length        = 24'd144000;
      index         = '0;
      phase         = '0;
      errors        = 0;
      reported      = 0;
    endfunction

    // Folds the angle into the first quadrant and sums the Taylor series in Q30.
    function int sine_point(int unsigned k, int unsigned depth);
      logic [63:0] d;
      logic [63:0] n;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] mag;
      logic        neg;
      int          j;
      d   = 64'(depth);
      n   = (64'(k) * 64'd4) % (d * 64'd4);
      neg = 1'b0;
      if (n >= 2 * d) begin
        neg = 1'b1;
        n   = n - 2 * d;
      end
      if (n > d) n = 2 * d - n;
      x    = (n * 64'd1686629713) / d;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (j = 1; j <= 6; j++) begin
        term = (term * x2) >> 30;
        term = term / (64'(2 * j) * 64'(2 * j + 1));
        if (j % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      mag = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) mag = 64'd32767;
      return neg ? -int'(mag) : int'(mag);
    endfunction

    function int gain_scale(int v, logic [15:0] g);
      logic [63:0] m;
      m = (v < 0) ? 64'(-v) : 64'(v);
      m = (m * g + 64'd32768) >> 16;
      return (v < 0) ? -int'(m) : int'(m);
    endfunction

    function void write_reg(cfg_reg_t r, logic [31:0] v);
      case (r)
        CFG_TONE_PHASE_STEP:   phase_step    = v;
        CFG_LEAD_IN_GAIN:      lead_gain     = v[15:0];
        CFG_TONE_GAIN:         tone_gain     = v[15:0];
        CFG_LEAD_IN_END:       lead_end      = v[23:0];
        CFG_FIRST_TICK_START:  tick_start[0] = v[23:0];
        CFG_SECOND_TICK_START: tick_start[1] = v[23:0];
        CFG_THIRD_TICK_START:  tick_start[2] = v[23:0];
        CFG_PATTERN_LENGTH:    length        = v[23:0];
        default: ;
      endcase
    endfunction

    function void note_period(logic rs);
      logic [15:0] amp;
      int          acc;
      int unsigned slot;
      int unsigned offs;
      int unsigned len;
      int          t;
      audio_item_t item;
      if (rs) begin
        index = '0;
        phase = '0;
      end
      amp = tone_gain;
      if (index < lead_end && lead_gain > tone_gain) amp = lead_gain;
      slot = 32'(({32'd0, phase} * SINE_DEPTH) >> 32);
      acc  = gain_scale(sine_tab[slot], amp);
      for (t = 0; t < 3; t++) begin
        if (index >= tick_start[t]) begin
          offs = index - tick_start[t];
          if (offs < TICK_LEN) acc += tick_tab[offs];
        end
      end
      if (acc > 32767) acc = 32767;
      if (acc < -32767) acc = -32767;
      len         = (length == 0) ? 1 : length;
      item.sample = acc[15:0];
      item.last   = (index + 32'd1 >= len);
      due_samples.push_back(item);
      if (item.last) begin
        index = '0;
        phase = '0;
      end else begin
        index = index + 24'd1;
        phase = phase + phase_step;
      end
    endfunction

    function void check_sample(logic signed [15:0] s, logic e);
      audio_item_t want;
      if (due_samples.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("Unexpected audio transaction: sample %0d, end %0b", s, e);
        end
        return;
      end
      want = due_samples.pop_front();
      if (s !== want.sample || e !== want.last) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("Sample mismatch: expected %0d end %0b, got %0d end %0b",
                   want.sample, want.last, s, e);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   hold_cycles = 0;

  tone_scoreboard board = new();

  lttg_period_if period_ch();
  lttg_audio_if  audio_ch();
  lttg_cfg_if    cfg_ch();

  latency_tone_tick_generator_core #(
    .TICK_LENGTH      (TICK_LEN),
    .SINE_TABLE_DEPTH (SINE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .period (period_ch),
    .audio  (audio_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  task automatic send_period(input logic rs);
    period_ch.valid   <= 1'b1;
    period_ch.restart <= rs;
    do @(posedge clk); while (!(period_ch.valid === 1'b1 && period_ch.ready === 1'b1));
    board.note_period(rs);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      period_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic stop_offering();
    period_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (board.due_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
    board.write_reg(r, v);
  endtask

  task automatic apply_settings(input tone_settings_t s);
    stop_offering();
    wait_drained();
    write_reg(CFG_TONE_PHASE_STEP, s.phase_step);
    write_reg(CFG_LEAD_IN_GAIN, s.lead_gain);
    write_reg(CFG_TONE_GAIN, s.tone_gain);
    write_reg(CFG_LEAD_IN_END, s.lead_end);
    write_reg(CFG_FIRST_TICK_START, s.tick1);
    write_reg(CFG_SECOND_TICK_START, s.tick2);
    write_reg(CFG_THIRD_TICK_START, s.tick3);
    write_reg(CFG_PATTERN_LENGTH, s.length);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_items(input int n, input int restart_pct, input bit gappy);
    int left;
    left = 0;
    repeat (n) begin
      if (left == 0) begin
        left = $urandom_range(1, 24);
        if (gappy) pause_sender($urandom_range(0, 6));
      end
      send_period($urandom_range(0, 99) < restart_pct);
      left--;
    end
  endtask

  // The receiver holds off while a burst is offered, so the queue fills and the input stalls.
  task automatic press_queue();
    hold_cycles = 60;
    repeat (30) send_period($urandom_range(0, 19) == 0);
    stop_offering();
    wait_drained();
  endtask

  function automatic logic [31:0] widen(input logic [31:0] v, input int w);
    if ($urandom_range(0, 3) == 0) v = v | ($urandom << w);
    return v;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd65535;
      2: return $urandom_range(0, 400);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic tone_settings_t random_settings();
    tone_settings_t s;
    int             span;
    case ($urandom_range(0, 3))
      0: s.phase_step = 32'd0;
      1: s.phase_step = 32'hFFFF_FFFF;
      2: s.phase_step = $urandom_range(0, 32'h0800_0000);
      default: s.phase_step = $urandom;
    endcase
    case ($urandom_range(0, 11))
      0: s.length = 32'd0;
      1: s.length = 32'd1;
      2: s.length = 32'h00FF_FFFF;
      default: s.length = $urandom_range(2, 48);
    endcase
    span = (s.length >= 1 && s.length <= 48) ? int'(s.length) : 48;
    s.tick1 = ($urandom_range(0, 7) == 0) ? ($urandom & 32'hFF_FFFF) : $urandom_range(0, span + 3);
    s.tick2 = ($urandom_range(0, 7) == 0) ? ($urandom & 32'hFF_FFFF) : $urandom_range(0, span + 3);
    s.tick3 = ($urandom_range(0, 7) == 0) ? ($urandom & 32'hFF_FFFF) : $urandom_range(0, span + 3);
    s.lead_end  = ($urandom_range(0, 5) == 0) ? 32'hFF_FFFF : $urandom_range(0, span + 2);
    s.lead_gain = widen(pick_gain(), 16);
    s.tone_gain = widen(pick_gain(), 16);
    s.lead_end  = widen(s.lead_end, 24);
    s.tick1     = widen(s.tick1, 24);
    s.tick2     = widen(s.tick2, 24);
    s.tick3     = widen(s.tick3, 24);
    s.length    = widen(s.length, 24);
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst && audio_ch.valid === 1'b1 && audio_ch.ready === 1'b1) begin
      board.check_sample(audio_ch.sample, audio_ch.pattern_end);
    end
  end

  initial begin
    logic [31:0] stall_word;
    int          pos;
    int          mode;
    audio_ch.ready <= 1'b0;
    stall_word = '0;
    pos        = 0;
    mode       = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        audio_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (pos == 0) begin
          stall_word = $urandom;
          mode       = $urandom_range(0, 3);
        end
        case (mode)
          0: audio_ch.ready <= 1'b1;
          1: audio_ch.ready <= stall_word[pos];
          2: audio_ch.ready <= stall_word[pos] | stall_word[(pos + 7) % 32];
          default: audio_ch.ready <= stall_word[pos] & stall_word[(pos + 7) % 32];
        endcase
        pos = (pos + 1) % 32;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (period_ch.valid && period_ch.ready) || (audio_ch.valid && audio_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int i;
    int p;
    rst               <= 1'b1;
    period_ch.valid   <= 1'b0;
    period_ch.restart <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_TONE_PHASE_STEP;
    cfg_ch.data       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Register defaults after reset, with one restart.
    send_period(1'b0);
    send_period(1'b0);
    send_period(1'b1);

    // Quarter-turn tone at full lead-in gain with overlapping ticks: the positive saturation
    // limit, a tick cut off at the pattern end, the wrap and a restart.
    apply_settings('{32'h4000_0000, 32'h0000_FFFF, 32'd0, 32'd6, 32'd0, 32'd2, 32'd6, 32'd8});
    for (i = 0; i < 10; i++) send_period(i == 9);

    // Lead-in gain below tone gain, oversized register values, zero pattern length.
    apply_settings('{32'hFFFF_FFFF, 32'hFFFF_0064, 32'h0000_FFFF, 32'h00FF_FFFF,
                     32'h00FF_FFFF, 32'hFF00_0005, 32'hABFF_FFF0, 32'h0000_0000});
    send_period(1'b1);
    send_period(1'b0);
    send_period(1'b1);

    // Pattern length shortened below the running index.
    apply_settings('{32'd0, 32'd0, 32'd65535, 32'd0, 32'd2, 32'd3, 32'd4, 32'h00FF_FFFF});
    repeat (6) send_period(1'b0);
    apply_settings('{32'd12345, 32'd500, 32'd300, 32'd5, 32'd1, 32'd7, 32'd9, 32'd3});
    repeat (2) send_period(1'b0);

    for (p = 0; p < 8; p++) begin
      apply_settings(random_settings());
      if (p == 3) press_queue();
      run_items(62, $urandom_range(0, 12), p % 3 != 0);
    end

    stop_offering();
    wait_drained();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.due_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
